// ----- src/number_to_ascii_formatter_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the number to ASCII formatter
// Shared property wrappers clocked on clk, with and without reset gating.
// ----------------------------------------------------------------------------
`ifndef NUMBER_TO_ASCII_FORMATTER_ASSERT_SVH
`define NUMBER_TO_ASCII_FORMATTER_ASSERT_SVH

// Property checked only while the block is out of reset.
`define N2A_ASSERT_RUN(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every edge, reset included.
`define N2A_ASSERT_ALL(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/n2a_pkg.sv -----
// ----------------------------------------------------------------------------
// Number to ASCII formatter package
// Widths, character codes and the nibble to character mapping.
// ----------------------------------------------------------------------------
package n2a_pkg;

  localparam int VALUE_BITS = 32;
  localparam int HEX_DIGITS = (VALUE_BITS + 3) / 4;
  localparam int HEX_W      = HEX_DIGITS * 4;
  // Decimal digits needed for the largest unsigned value of VALUE_BITS bits.
  localparam int DEC_DIGITS = (VALUE_BITS * 30103 + 99999) / 100000;
  localparam int DEC_W      = DEC_DIGITS * 4;
  localparam int DIGITS_MAX = (DEC_DIGITS > HEX_DIGITS) ? DEC_DIGITS : HEX_DIGITS;
  localparam int EMIT_W     = DIGITS_MAX * 4;
  localparam int CNT_W      = $clog2(DIGITS_MAX + 1);
  localparam int STEP_W     = $clog2(VALUE_BITS + 1);

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_X    = 8'h78;
  localparam logic [7:0] CHAR_A    = 8'h41;

  localparam logic [0:0] REQ_HEX = 1'b0;
  localparam logic [0:0] REQ_DEC = 1'b1;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] code;
    if (nib > 4'd9) begin
      code = CHAR_A + {4'h0, nib} - 8'd10;
    end else begin
      code = CHAR_ZERO + {4'h0, nib};
    end
    return code;
  endfunction

endpackage

// ----- src/number_to_ascii_formatter.sv -----
// ----------------------------------------------------------------------------
// Number to ASCII formatter
// Formats an unsigned value as "0x" plus uppercase hex digits, or as decimal
// digits without leading zeros, one character per output transfer.
//
//   Channel  Direction  tdata            tuser     tlast
//   in_      slave      value[31:0]      req_type  -
//   out_     master     char_code[7:0]   -         last_char
//
// A hexadecimal request is loaded, then "0x" and eight hex digits are emitted.
// A decimal request is loaded and converted in the shift and add-3 BCD unit,
// whose result is then taken; the leading zeros are dropped one digit at a
// time, the zero scan ends and the remaining digits are emitted.
// The input is ready only while no request is being worked on.
// Output stalls hold the sequencer; reset is synchronous and clears control.
// ----------------------------------------------------------------------------
module number_to_ascii_formatter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // value[31:0]
  input  logic        in_tuser,   // req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // char_code[7:0]
  output logic        out_tlast
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CONV = 3'd1;
  localparam logic [2:0] ST_SKIP = 3'd2;
  localparam logic [2:0] ST_PRE0 = 3'd3;
  localparam logic [2:0] ST_PRE1 = 3'd4;
  localparam logic [2:0] ST_DIG  = 3'd5;

  logic [2:0]                  state_r, state_nxt;
  logic [n2a_pkg::EMIT_W-1:0]  emit_r, emit_nxt;
  logic [n2a_pkg::CNT_W-1:0]   remain_r, remain_nxt;
  logic [7:0]                  out_data_r, out_data_nxt;
  logic                        out_last_r, out_last_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic                        load_ok;
  logic                        bcd_start;
  logic                        bcd_done;
  logic [n2a_pkg::DEC_W-1:0]   bcd;
  logic [3:0]                  top_nib;

  n2a_bcd_conv u_bcd (
    .clk   (clk),
    .rst_n (rst_n),
    .start (bcd_start),
    .value (in_tdata[n2a_pkg::VALUE_BITS-1:0]),
    .done  (bcd_done),
    .bcd   (bcd)
  );

  assign in_tready = (state_r == ST_IDLE);
  assign load_ok   = !out_valid_r || out_tready;
  assign top_nib   = emit_r[n2a_pkg::EMIT_W-1 -: 4];

  always_comb begin
    state_nxt     = state_r;
    emit_nxt      = emit_r;
    remain_nxt    = remain_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r;
    bcd_start     = 1'b0;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          if (in_tuser == n2a_pkg::REQ_DEC) begin
            bcd_start = 1'b1;
            state_nxt = ST_CONV;
          end else begin
            emit_nxt = n2a_pkg::EMIT_W'(in_tdata[n2a_pkg::VALUE_BITS-1:0])
                       << (n2a_pkg::EMIT_W - n2a_pkg::HEX_W);
            remain_nxt = n2a_pkg::CNT_W'(n2a_pkg::HEX_DIGITS);
            state_nxt  = ST_PRE0;
          end
        end
      end
      ST_CONV: begin
        if (bcd_done) begin
          emit_nxt   = n2a_pkg::EMIT_W'(bcd) << (n2a_pkg::EMIT_W - n2a_pkg::DEC_W);
          remain_nxt = n2a_pkg::CNT_W'(n2a_pkg::DEC_DIGITS);
          state_nxt  = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (top_nib == 4'd0 && remain_r > n2a_pkg::CNT_W'(1)) begin
          emit_nxt   = emit_r << 4;
          remain_nxt = remain_r - 1'b1;
        end else begin
          state_nxt = ST_DIG;
        end
      end
      ST_PRE0: begin
        if (load_ok) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = n2a_pkg::CHAR_ZERO;
          out_last_nxt  = 1'b0;
          state_nxt     = ST_PRE1;
        end
      end
      ST_PRE1: begin
        if (load_ok) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = n2a_pkg::CHAR_X;
          out_last_nxt  = 1'b0;
          state_nxt     = ST_DIG;
        end
      end
      ST_DIG: begin
        if (load_ok) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = n2a_pkg::hex_char(top_nib);
          out_last_nxt  = (remain_r == n2a_pkg::CNT_W'(1));
          emit_nxt      = emit_r << 4;
          remain_nxt    = remain_r - 1'b1;
          if (remain_r == n2a_pkg::CNT_W'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    emit_r     <= emit_nxt;
    remain_r   <= remain_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

// ----- src/n2a_bcd_conv.sv -----
// ----------------------------------------------------------------------------
// Binary to BCD converter
// Shift and add-3 unit, one bit of the binary value per cycle.
// ----------------------------------------------------------------------------
module n2a_bcd_conv (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [n2a_pkg::VALUE_BITS-1:0] value,
  output logic                          done,
  output logic [n2a_pkg::DEC_W-1:0]     bcd
);

  logic [n2a_pkg::VALUE_BITS-1:0] bin_r, bin_nxt;
  logic [n2a_pkg::DEC_W-1:0]      bcd_r, bcd_nxt, bcd_adj;
  logic [n2a_pkg::STEP_W-1:0]     step_r, step_nxt;
  logic                           busy_r, busy_nxt;
  logic                           done_r, done_nxt;

  always_comb begin
    for (int d = 0; d < n2a_pkg::DEC_DIGITS; d++) begin
      if (bcd_r[4*d +: 4] >= 4'd5) begin
        bcd_adj[4*d +: 4] = bcd_r[4*d +: 4] + 4'd3;
      end else begin
        bcd_adj[4*d +: 4] = bcd_r[4*d +: 4];
      end
    end
  end

  always_comb begin
    bin_nxt  = bin_r;
    bcd_nxt  = bcd_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      bin_nxt  = value;
      bcd_nxt  = '0;
      step_nxt = n2a_pkg::STEP_W'(n2a_pkg::VALUE_BITS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      bcd_nxt  = {bcd_adj[n2a_pkg::DEC_W-2:0], bin_r[n2a_pkg::VALUE_BITS-1]};
      bin_nxt  = {bin_r[n2a_pkg::VALUE_BITS-2:0], 1'b0};
      step_nxt = step_r - 1'b1;
      if (step_r == n2a_pkg::STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    bin_r  <= bin_nxt;
    bcd_r  <= bcd_nxt;
    step_r <= step_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign bcd  = bcd_r;

endmodule

// ----- src/n2a_checker.sv -----
// ----------------------------------------------------------------------------
// Number to ASCII formatter port checker
// Checks stream behavior and character codes seen on the top-level ports.
// ----------------------------------------------------------------------------
`include "number_to_ascii_formatter_assert.svh"

module n2a_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata,
  input logic        out_tlast
);

  logic in_xfer;
  logic char_ok;

  assign in_xfer = in_tvalid && in_tready;
  assign char_ok = (out_tdata >= 8'h30 && out_tdata <= 8'h39) ||
                   (out_tdata >= 8'h41 && out_tdata <= 8'h46) ||
                   (out_tdata == 8'h78);

  // A stalled output transfer keeps its character and end marker.
  `N2A_ASSERT_RUN(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast), "output changed while stalled")
  // The cycle after an input transfer the block is busy and its input not ready.
  `N2A_ASSERT_RUN(a_busy_after_in, in_xfer |=> !in_tready, "input ready right after a transfer")
  // While a new number may enter, only the final character can still wait.
  `N2A_ASSERT_RUN(a_idle_last, out_tvalid && in_tready |-> out_tlast, "idle with an unfinished run")
  // Every character is a digit, an uppercase hex letter or the x of the prefix.
  `N2A_ASSERT_RUN(a_char_set, out_tvalid |-> char_ok, "unexpected character code")
  // Reset leaves the output empty and the input ready.
  `N2A_ASSERT_ALL(a_reset, !rst_n |=> !out_tvalid && in_tready, "bad state after reset")

endmodule

bind number_to_ascii_formatter n2a_checker u_n2a_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

// ----- test/tb_number_to_ascii_formatter.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the number to ASCII formatter
// Sends hexadecimal and decimal requests, predicts every character of each
// text run and compares the character stream, including the last-character
// marker, against the prediction while both sides stall at random.
// ----------------------------------------------------------------------------
module tb_number_to_ascii_formatter;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } text_char_t;

  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 60;
  localparam int HOLD_CYCLES  = 300;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;
  logic        in_tuser   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tlast;

  text_char_t pending_chars[$];
  int         error_count  = 0;
  int         stall_cycles = 0;
  int         hold_left    = 0;
  bit         quiet        = 1'b0;

  number_to_ascii_formatter u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void predict_text(input logic [0:0] req, input logic [31:0] val);
    logic [7:0]  digits [10];
    logic [31:0] rest;
    logic [3:0]  nib;
    int          len;
    text_char_t  ch;
    if (req == n2a_pkg::REQ_HEX) begin
      pending_chars.push_back(text_char_t'{n2a_pkg::CHAR_ZERO, 1'b0});
      pending_chars.push_back(text_char_t'{n2a_pkg::CHAR_X, 1'b0});
      for (int i = n2a_pkg::HEX_DIGITS - 1; i >= 0; i--) begin
        nib = val[i*4 +: 4];
        ch.code = (nib > 4'd9) ? n2a_pkg::CHAR_A + {4'h0, nib} - 8'd10
                               : n2a_pkg::CHAR_ZERO + {4'h0, nib};
        ch.last = (i == 0);
        pending_chars.push_back(ch);
      end
    end else begin
      rest = val;
      len  = 0;
      do begin
        digits[len] = n2a_pkg::CHAR_ZERO + 8'(rest % 32'd10);
        rest = rest / 32'd10;
        len++;
      end while (rest != 0);
      for (int i = len - 1; i >= 0; i--) begin
        pending_chars.push_back(text_char_t'{digits[i], i == 0});
      end
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] want,
                                 input logic [7:0] got);
    $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
    error_count++;
  endtask

  task automatic check_char(input logic [7:0] code, input logic last);
    text_char_t want;
    if (pending_chars.size() == 0) begin
      report_mismatch("unexpected character", 8'h00, code);
    end else begin
      want = pending_chars.pop_front();
      if (code !== want.code) report_mismatch("char_code", want.code, code);
      if (last !== want.last) report_mismatch("last_char", {7'h0, want.last}, {7'h0, last});
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) predict_text(in_tuser, in_tdata);
      if (out_tvalid && out_tready) check_char(out_tdata, out_tlast);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (quiet) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(99) >= 18);
      end
    end
  end

  task automatic send_number(input logic [0:0] req, input logic [31:0] val);
    while (!quiet && $urandom_range(99) < 18) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= val;
    in_tuser  <= req;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  function automatic logic [31:0] random_number();
    logic [31:0] p;
    int          k;
    p = 32'd1;
    case ($urandom_range(2))
      0: return $urandom;
      1: return $urandom >> $urandom_range(31);
      default: begin
        k = $urandom_range(9);
        for (int i = 0; i < k; i++) p = p * 32'd10;
        return p - $urandom_range(1);
      end
    endcase
  endfunction

  task automatic test_hex_extremes();
    send_number(n2a_pkg::REQ_HEX, 32'h0000_0000);
    send_number(n2a_pkg::REQ_HEX, 32'hFFFF_FFFF);
    send_number(n2a_pkg::REQ_HEX, 32'h1234_5678);
    send_number(n2a_pkg::REQ_HEX, 32'h89AB_CDEF);
    send_number(n2a_pkg::REQ_HEX, 32'h8000_0000);
    send_number(n2a_pkg::REQ_HEX, 32'h0000_0001);
    send_number(n2a_pkg::REQ_HEX, 32'hA5A5_A5A5);
    send_number(n2a_pkg::REQ_HEX, 32'h5A5A_5A5A);
  endtask

  // Zero must print as a single digit; the others cover one, two, three, nine and ten digits.
  task automatic test_decimal_extremes();
    send_number(n2a_pkg::REQ_DEC, 32'd0);
    send_number(n2a_pkg::REQ_DEC, 32'd1);
    send_number(n2a_pkg::REQ_DEC, 32'd9);
    send_number(n2a_pkg::REQ_DEC, 32'd10);
    send_number(n2a_pkg::REQ_DEC, 32'd99);
    send_number(n2a_pkg::REQ_DEC, 32'd100);
    send_number(n2a_pkg::REQ_DEC, 32'd999_999_999);
    send_number(n2a_pkg::REQ_DEC, 32'd1_000_000_000);
    send_number(n2a_pkg::REQ_DEC, 32'd1_234_567_890);
    send_number(n2a_pkg::REQ_DEC, 32'h8000_0000);
    send_number(n2a_pkg::REQ_DEC, 32'hFFFF_FFFF);
  endtask

  task automatic test_random_mix(input int count);
    for (int i = 0; i < count; i++) begin
      send_number(1'($urandom_range(1)), random_number());
    end
  endtask

  task automatic test_no_idle_stretch(input int count);
    quiet = 1'b1;
    for (int i = 0; i < count; i++) begin
      send_number(1'($urandom_range(1)), random_number());
    end
    quiet = 1'b0;
  endtask

  // The receiver holds off long enough for the block to stall its input.
  task automatic test_output_hold(input int count);
    hold_left = HOLD_CYCLES;
    for (int i = 0; i < count; i++) begin
      send_number(1'($urandom_range(1)), random_number());
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_hex_extremes();
    test_decimal_extremes();
    test_random_mix(91);
    test_no_idle_stretch(30);
    test_output_hold(10);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_chars.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
